FILE: sv/pfb_pkg.sv
// Shared types and constants for the page frame buffer draw engine.
// Holds command modes, the controller states and the control/status structs.
// No dependencies.
package pfb_pkg;

  localparam int unsigned ROWS_PER_PAGE = 8;

  typedef enum logic [2:0] {
    MODE_PIXEL       = 3'd0,
    MODE_RECT_CLEAR  = 3'd1,
    MODE_RECT_INVERT = 3'd2,
    MODE_BLIT        = 3'd3,
    MODE_READ        = 3'd4,
    MODE_CLEAR_ALL   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_RMW,
    KIND_READ,
    KIND_CLEAR
  } kind_e;

  typedef enum logic [2:0] {
    S_WIPE,
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_WRITE,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [8:0] x_pos;
    logic signed [8:0] y_pos;
    logic [7:0]        rect_width;
    logic [7:0]        rect_height;
    logic              pixel_value;
    logic [7:0]        pattern_byte;
  } cmd_t;

  typedef struct packed {
    logic ram_en;
    logic ram_we;
    logic sel_clear;
    logic clr_step;
    logic load_cmd;
    logic advance;
    logic load_res;
  } ctrl_t;

  typedef struct packed {
    kind_e kind;
    logic  is_read;
    logic  last;
    logic  clr_last;
    logic  out_free;
  } stat_t;

endpackage

FILE: sv/pfb_if.sv
// Valid/ready channel interfaces for command and result words.
// Depends on nothing.
interface pfb_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic signed [8:0] x_pos;
  logic signed [8:0] y_pos;
  logic [7:0]        rect_width;
  logic [7:0]        rect_height;
  logic              pixel_value;
  logic [7:0]        pattern_byte;

  modport source (output valid, mode, x_pos, y_pos, rect_width, rect_height,
                  pixel_value, pattern_byte, input ready);
  modport sink (input valid, mode, x_pos, y_pos, rect_width, rect_height,
                pixel_value, pattern_byte, output ready);
endinterface

interface pfb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       nothing_drawn;

  modport source (output valid, read_data, nothing_drawn, input ready);
  modport sink (input valid, read_data, nothing_drawn, output ready);
endinterface

FILE: sv/page_framebuffer_draw_engine.sv
// From accept to result valid: pixel, rectangle and blit words do a RAM read then a write per
// touched byte; read does one RAM read; clear all writes every byte; nothing touched goes straight to the result.
// One word in flight; the next accept comes in the cycle after the result loads, and each
// touched byte takes a read then a write on the single RAM port.
// Reset: async active low; a wipe over all SCREEN_COLUMNS*SCREEN_PAGES bytes zeroes the store
// with cmd ready low. Depends on pfb_pkg, pfb_if, pfb_ctrl, pfb_datapath.
module page_framebuffer_draw_engine #(
  parameter int unsigned SCREEN_COLUMNS = 128,
  parameter int unsigned SCREEN_PAGES   = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfb_cmd_if.sink   cmd_i,
  pfb_res_if.source res_o
);

  pfb_pkg::cmd_t  cmd;
  pfb_pkg::ctrl_t ctrl;
  pfb_pkg::stat_t stat;

  assign cmd.mode         = cmd_i.mode;
  assign cmd.x_pos        = cmd_i.x_pos;
  assign cmd.y_pos        = cmd_i.y_pos;
  assign cmd.rect_width   = cmd_i.rect_width;
  assign cmd.rect_height  = cmd_i.rect_height;
  assign cmd.pixel_value  = cmd_i.pixel_value;
  assign cmd.pattern_byte = cmd_i.pattern_byte;

  pfb_ctrl u_pfb_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  pfb_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_PAGES   (SCREEN_PAGES)
  ) u_pfb_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .res_valid_o     (res_o.valid),
    .res_ready_i     (res_o.ready),
    .read_data_o     (res_o.read_data),
    .nothing_drawn_o (res_o.nothing_drawn)
  );

endmodule

FILE: sv/pfb_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module pfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/pfb_ctrl.sv
// Controller state machine: reset wipe, command sequencing, result hand-off.
// Depends on pfb_pkg.
module pfb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  pfb_pkg::stat_t stat_i,
  output pfb_pkg::ctrl_t ctrl_o
);

  pfb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfb_pkg::S_WIPE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    cmd_ready_o = 1'b0;
    unique case (state_q)
      pfb_pkg::S_WIPE, pfb_pkg::S_CLEAR: begin
        ctrl_o.ram_en    = 1'b1;
        ctrl_o.ram_we    = 1'b1;
        ctrl_o.sel_clear = 1'b1;
        ctrl_o.clr_step  = 1'b1;
        if (stat_i.clr_last) begin
          state_d = (state_q == pfb_pkg::S_WIPE) ? pfb_pkg::S_IDLE : pfb_pkg::S_FIN;
        end
      end
      pfb_pkg::S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          ctrl_o.load_cmd = 1'b1;
          unique case (stat_i.kind)
            pfb_pkg::KIND_NONE:  state_d = pfb_pkg::S_FIN;
            pfb_pkg::KIND_CLEAR: state_d = pfb_pkg::S_CLEAR;
            pfb_pkg::KIND_RMW,
            pfb_pkg::KIND_READ:  state_d = pfb_pkg::S_READ;
            default:             state_d = pfb_pkg::S_FIN;
          endcase
        end
      end
      pfb_pkg::S_READ: begin
        ctrl_o.ram_en = 1'b1;
        state_d = stat_i.is_read ? pfb_pkg::S_FIN : pfb_pkg::S_WRITE;
      end
      pfb_pkg::S_WRITE: begin
        ctrl_o.ram_en  = 1'b1;
        ctrl_o.ram_we  = 1'b1;
        ctrl_o.advance = 1'b1;
        if (!stat_i.last) begin
          state_d = pfb_pkg::S_READ;
        end else if (stat_i.out_free) begin
          ctrl_o.load_res = 1'b1;
          state_d = pfb_pkg::S_IDLE;
        end else begin
          state_d = pfb_pkg::S_FIN;
        end
      end
      pfb_pkg::S_FIN: begin
        if (stat_i.out_free) begin
          ctrl_o.load_res = 1'b1;
          state_d = pfb_pkg::S_IDLE;
        end
      end
      default: state_d = pfb_pkg::S_WIPE;
    endcase
  end

endmodule

FILE: sv/pfb_datapath.sv
// Datapath: command decode and clipping, page/column walk, byte merge,
// frame store RAM, clear sweep counter and result register.
// Depends on pfb_pkg and pfb_ram.
module pfb_datapath #(
  parameter int unsigned SCREEN_COLUMNS = 128,
  parameter int unsigned SCREEN_PAGES   = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pfb_pkg::cmd_t  cmd_i,
  input  pfb_pkg::ctrl_t ctrl_i,
  output pfb_pkg::stat_t stat_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic [7:0]     read_data_o,
  output logic           nothing_drawn_o
);

  localparam int unsigned CW    = $clog2(SCREEN_COLUMNS);
  localparam int unsigned PW    = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
  localparam int unsigned DEPTH = SCREEN_COLUMNS * SCREEN_PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned ROWS  = SCREEN_PAGES * pfb_pkg::ROWS_PER_PAGE;

  // decode of the incoming word
  logic       x_nn, y_nn, col_in, row_in, page_in, rect_ok, p0_ok, p1_ok, touched;
  logic [7:0] x_u, y_u;
  logic [8:0] x_end, x_lim, x_last, y_end, y_lim, y_last;
  logic [6:0] p0, p1;
  logic [2:0] sft_in;
  pfb_pkg::mode_e mode_in;
  pfb_pkg::kind_e kind;

  assign mode_in = pfb_pkg::mode_e'(cmd_i.mode);
  assign x_nn    = !cmd_i.x_pos[8];
  assign y_nn    = !cmd_i.y_pos[8];
  assign x_u     = cmd_i.x_pos[7:0];
  assign y_u     = cmd_i.y_pos[7:0];
  assign sft_in  = cmd_i.y_pos[2:0];
  assign col_in  = x_nn && ({1'b0, x_u} < 9'(SCREEN_COLUMNS));
  assign row_in  = y_nn && ({1'b0, y_u} < 9'(ROWS));
  assign page_in = y_nn && ({1'b0, y_u} < 9'(SCREEN_PAGES));
  assign x_end   = {1'b0, x_u} + {1'b0, cmd_i.rect_width};
  assign x_lim   = (x_end < 9'(SCREEN_COLUMNS)) ? x_end : 9'(SCREEN_COLUMNS);
  assign x_last  = x_lim - 9'd1;
  assign y_end   = {1'b0, y_u} + {1'b0, cmd_i.rect_height};
  assign y_lim   = (y_end < 9'(ROWS)) ? y_end : 9'(ROWS);
  assign y_last  = y_lim - 9'd1;
  assign rect_ok = col_in && row_in && (cmd_i.rect_width != 8'd0)
                   && (cmd_i.rect_height != 8'd0);
  assign p0      = {cmd_i.y_pos[8], cmd_i.y_pos[8:3]};
  assign p1      = p0 + 7'd1;
  assign p0_ok   = !p0[6] && (p0 < 7'(SCREEN_PAGES));
  assign p1_ok   = (sft_in != 3'd0) && !p1[6] && (p1 < 7'(SCREEN_PAGES));

  always_comb begin
    unique case (mode_in)
      pfb_pkg::MODE_PIXEL: begin
        touched = col_in && row_in;
        kind    = touched ? pfb_pkg::KIND_RMW : pfb_pkg::KIND_NONE;
      end
      pfb_pkg::MODE_RECT_CLEAR, pfb_pkg::MODE_RECT_INVERT: begin
        touched = rect_ok;
        kind    = touched ? pfb_pkg::KIND_RMW : pfb_pkg::KIND_NONE;
      end
      pfb_pkg::MODE_BLIT: begin
        touched = col_in && (p0_ok || p1_ok);
        kind    = touched ? pfb_pkg::KIND_RMW : pfb_pkg::KIND_NONE;
      end
      pfb_pkg::MODE_READ: begin
        touched = col_in && page_in;
        kind    = touched ? pfb_pkg::KIND_READ : pfb_pkg::KIND_NONE;
      end
      pfb_pkg::MODE_CLEAR_ALL: begin
        touched = 1'b1;
        kind    = pfb_pkg::KIND_CLEAR;
      end
      default: begin
        touched = 1'b0;
        kind    = pfb_pkg::KIND_NONE;
      end
    endcase
  end

  // command registers and walk counters
  pfb_pkg::mode_e op_q;
  logic           touched_q, pv_q, hi_q;
  logic [7:0]     pat_q;
  logic [2:0]     sft_q, end_q;
  logic [CW-1:0]  col_q, col_first_q, col_last_q;
  logic [PW-1:0]  page_q, page_last_q;
  logic           last;

  assign last = (col_q == col_last_q) && (page_q == page_last_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_cmd) begin
      op_q        <= mode_in;
      touched_q   <= touched;
      pv_q        <= cmd_i.pixel_value;
      pat_q       <= cmd_i.pattern_byte;
      sft_q       <= sft_in;
      col_q       <= x_u[CW-1:0];
      col_first_q <= x_u[CW-1:0];
      hi_q        <= 1'b0;
      unique case (mode_in)
        pfb_pkg::MODE_RECT_CLEAR, pfb_pkg::MODE_RECT_INVERT: begin
          end_q       <= y_last[2:0];
          col_last_q  <= x_last[CW-1:0];
          page_q      <= y_u[PW+2:3];
          page_last_q <= y_last[PW+2:3];
        end
        pfb_pkg::MODE_BLIT: begin
          end_q       <= sft_in - 3'd1;
          col_last_q  <= x_u[CW-1:0];
          page_q      <= p0_ok ? p0[PW-1:0] : p1[PW-1:0];
          page_last_q <= p1_ok ? p1[PW-1:0] : p0[PW-1:0];
          hi_q        <= !p0_ok;
        end
        pfb_pkg::MODE_READ: begin
          end_q       <= sft_in;
          col_last_q  <= x_u[CW-1:0];
          page_q      <= y_u[PW-1:0];
          page_last_q <= y_u[PW-1:0];
        end
        default: begin
          end_q       <= sft_in;
          col_last_q  <= x_u[CW-1:0];
          page_q      <= y_u[PW+2:3];
          page_last_q <= y_u[PW+2:3];
        end
      endcase
    end else if (ctrl_i.advance) begin
      if (col_q == col_last_q) begin
        col_q  <= col_first_q;
        page_q <= page_q + PW'(1);
        hi_q   <= 1'b1;
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // byte merge
  logic [7:0]  ram_rdata, mask, set_bits, merged;
  logic [2:0]  lo_bit, hi_bit;
  logic [15:0] blit_wide;

  assign lo_bit = hi_q ? 3'd0 : sft_q;
  assign hi_bit = ((page_q == page_last_q) && ((op_q != pfb_pkg::MODE_BLIT) || hi_q))
                  ? end_q : 3'd7;
  assign mask      = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
  assign blit_wide = {8'h00, pat_q} << sft_q;

  always_comb begin
    unique case (op_q)
      pfb_pkg::MODE_PIXEL: set_bits = {8{pv_q}};
      pfb_pkg::MODE_BLIT:  set_bits = hi_q ? blit_wide[15:8] : blit_wide[7:0];
      default:             set_bits = 8'h00;
    endcase
    if (op_q == pfb_pkg::MODE_RECT_INVERT) begin
      merged = ram_rdata ^ mask;
    end else begin
      merged = (ram_rdata & ~mask) | (set_bits & mask);
    end
  end

  // clear sweep counter
  logic [AW-1:0] clr_q;
  logic          clr_last;

  assign clr_last = (clr_q == AW'(DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl_i.clr_step) begin
      clr_q <= clr_last ? '0 : clr_q + AW'(1);
    end
  end

  // frame store
  logic [AW:0]   walk_addr;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;

  assign walk_addr = (AW + 1)'(page_q) * (AW + 1)'(SCREEN_COLUMNS) + (AW + 1)'(col_q);
  assign ram_addr  = ctrl_i.sel_clear ? clr_q : walk_addr[AW-1:0];
  assign ram_wdata = ctrl_i.sel_clear ? 8'h00 : merged;

  pfb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_pfb_ram (
    .clk_i   (clk_i),
    .en_i    (ctrl_i.ram_en),
    .we_i    (ctrl_i.ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // result register
  logic       res_valid_q, nothing_drawn_q;
  logic [7:0] read_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (ctrl_i.load_res) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_res) begin
      read_data_q     <= ((op_q == pfb_pkg::MODE_READ) && touched_q) ? ram_rdata : 8'h00;
      nothing_drawn_q <= !touched_q;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign read_data_o     = read_data_q;
  assign nothing_drawn_o = nothing_drawn_q;

  assign stat_o.kind     = kind;
  assign stat_o.is_read  = (op_q == pfb_pkg::MODE_READ);
  assign stat_o.last     = last;
  assign stat_o.clr_last = clr_last;
  assign stat_o.out_free = !res_valid_q || res_ready_i;

endmodule

FILE: sv/pfb_checker.sv
// Port-level checks for the draw engine, bound to the top level.
// Depends on page_framebuffer_draw_engine.
module pfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cmd_valid_i,
  input logic       cmd_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] read_data_i,
  input logic       nothing_drawn_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(read_data_i)
                                   && $stable(nothing_drawn_i))
    else $error("result word changed while stalled");

  a_data_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (read_data_i != 8'h00) |-> !nothing_drawn_i)
    else $error("read data with nothing_drawn set");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command accepted while busy");

  a_wipe_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !cmd_ready_i && !res_valid_i)
    else $error("ready or result right after reset");

endmodule

bind page_framebuffer_draw_engine pfb_checker u_pfb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cmd_valid_i     (cmd_i.valid),
  .cmd_ready_i     (cmd_i.ready),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .read_data_i     (res_o.read_data),
  .nothing_drawn_i (res_o.nothing_drawn)
);
